// ===== hdl/lru_key_value_cache_assert.svh =====
// assertion macros for the lru key-value cache checker
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

// ===== hdl/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

  localparam int KeyW = 32;
  localparam int DataW = 32;
  localparam int CapW = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic ReqSet = 1'b0;
  localparam logic ReqGet = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [KeyW-1:0]  req_key;
    logic signed [DataW-1:0] req_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] data;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                   exec;
    logic                   is_get;
    logic                   hit;
    logic                   full;
    logic signed [KeyW-1:0] key;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lkvc_cell.sv =====
`default_nettype none

module lkvc_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lkvc_pkg::ctl_t                ctl_i,
  input  wire lkvc_pkg::entry_t              prev_i,
  input  wire logic                          found_i,
  input  wire logic [lkvc_pkg::DataW-1:0]    acc_i,
  output lkvc_pkg::entry_t                   ent_o,
  output logic                               found_o,
  output logic [lkvc_pkg::DataW-1:0]         acc_o
);
  import lkvc_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [KeyW-1:0]  key_q;
  logic signed [DataW-1:0] data_q;
  logic                    match;
  logic                    shift;
  logic                    valid_upd;

  assign match   = valid_q && (key_q == ctl_i.key);
  assign found_o = found_i | match;
  assign acc_o   = acc_i | (match ? data_q : '0);

  // hit: cells up to the hit position take their neighbor's entry
  // miss on set: every cell behind a valid one takes its neighbor's entry
  assign shift = ctl_i.exec &&
                 (ctl_i.hit ? !found_i : ((ctl_i.is_get == ReqSet) && prev_i.valid));

  // valid prefix grows by one only on a set miss below capacity
  assign valid_upd = ctl_i.exec && !ctl_i.hit && (ctl_i.is_get == ReqSet) && !ctl_i.full;
  assign valid_d   = valid_upd ? prev_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q  <= prev_i.key;
      data_q <= prev_i.data;
    end
  end

  assign ent_o.valid = valid_q;
  assign ent_o.key   = key_q;
  assign ent_o.data  = data_q;

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// a get request is registered in req_q, executes while busy_q is set, and its result is registered in out_q
// the input stalls while a request executes, so no new request is taken before the last is through; the key match
//   and the shift toward the front ripple through the chain of cells in the execute cycle
// a get result held by the receiver stalls the input until it transfers
// reset: all entries invalid (cache empty), capacity 16, no result pending
`default_nettype none

module lru_key_value_cache #(
  parameter int MaxEntries = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lkvc_pkg::CapW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire lkvc_pkg::req_t              in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output lkvc_pkg::rsp_t                   out_data_o
);
  import lkvc_pkg::*;

  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = ($clog2(MaxEntries + 1) > CapW) ? $clog2(MaxEntries + 1) : CapW;

  logic            busy_q;
  req_t            req_q;
  logic [CapW-1:0] capacity_q;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q;
  logic            accept;
  ctl_t            ctl;

  entry_t                  ent   [MaxEntries];
  entry_t                  prev  [MaxEntries];
  logic [MaxEntries:0]     found;
  logic [DataW-1:0]        acc   [MaxEntries+1];
  logic [MaxEntries-1:0]   valid_vec;

  logic [CntW-1:0] cap_ext, cap_eff, cap_m1;
  logic            full;
  logic            hit;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);

  // effective capacity saturates at the number of cells
  assign cap_ext = CntW'(capacity_q);
  assign cap_eff = (cap_ext > CntW'(MaxEntries)) ? CntW'(MaxEntries) : cap_ext;
  assign cap_m1  = cap_eff - CntW'(1);
  assign full    = (cap_eff == '0) || valid_vec[cap_m1[IdxW-1:0]];

  assign found[0] = 1'b0;
  assign acc[0]   = '0;
  assign hit      = found[MaxEntries];

  assign ctl.exec   = busy_q;
  assign ctl.is_get = req_q.req_type;
  assign ctl.hit    = hit;
  assign ctl.full   = full;
  assign ctl.key    = req_q.req_key;

  genvar g;
  generate
    for (g = 0; g < MaxEntries; g++) begin : g_cell
      if (g == 0) begin : g_front
        // the front cell is fed by the request itself
        assign prev[g].valid = 1'b1;
        assign prev[g].key   = req_q.req_key;
        assign prev[g].data  = (req_q.req_type == ReqGet) ? acc[MaxEntries]
                                                          : req_q.req_value;
      end else begin : g_rest
        assign prev[g] = ent[g-1];
      end

      lkvc_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .prev_i   (prev[g]),
        .found_i  (found[g]),
        .acc_i    (acc[g]),
        .ent_o    (ent[g]),
        .found_o  (found[g+1]),
        .acc_o    (acc[g+1])
      );

      assign valid_vec[g] = ent[g].valid;
    end
  endgenerate

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (busy_q && (req_q.req_type == ReqGet)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      capacity_q  <= CapReset;
    end else begin
      busy_q      <= accept;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (busy_q && (req_q.req_type == ReqGet)) begin
      out_q.hit        <= hit;
      out_q.read_value <= acc[MaxEntries];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/lkvc_checker.sv =====
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lkvc_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_o,
  input  wire lkvc_pkg::req_t              in_data_i,
  input  wire logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire lkvc_pkg::rsp_t              out_data_o
);
  import lkvc_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // a held result keeps its payload
  `LKVC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // one request at a time
  `LKVC_ASSERT_NEXT(a_one_at_a_time, in_xfer, in_stall_o)

  // every get gives a result, registered in out_q after the get executes
  `LKVC_ASSERT_NOW(a_get_result, in_xfer && (in_data_i.req_type == ReqGet), ##2 out_valid_o)

  // a set gives none
  `LKVC_ASSERT_NOW(a_set_silent, in_xfer && (in_data_i.req_type == ReqSet), ##2 !out_valid_o)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
